/* hw/rtl/mind_pkg.sv */
// ============================================================================
// mind_pkg: shared definitions for the minimum-image distance core
// Widths, register indexes, sequencer states and the control bundle that
// drives the shared multiply-accumulate unit.
// ============================================================================
package mind_pkg;

    // Default widths of positions and matrix coefficients.
    localparam int POS_WIDTH_DEF  = 24;
    localparam int COEF_WIDTH_DEF = 20;

    // Configuration register file.
    localparam int N_REGS    = 6;
    localparam int REG_W     = 60;
    localparam int CFG_IDX_W = 3;

    // Result fields.
    localparam int OUT_W = 24;

    // Fractional bits of the products in both matrix passes.
    localparam int FRAC_SHIFT = 26;
    // Width of a fractional remainder: |r| <= 2^(FRAC_SHIFT-1).
    localparam int REM_W = FRAC_SHIFT + 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes.
    localparam t_cfg_idx REG_INV_X  = 3'd0;
    localparam t_cfg_idx REG_INV_Y  = 3'd1;
    localparam t_cfg_idx REG_INV_Z  = 3'd2;
    localparam t_cfg_idx REG_CELL_A = 3'd3;
    localparam t_cfg_idx REG_CELL_B = 3'd4;
    localparam t_cfg_idx REG_CELL_C = 3'd5;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAC,
        S_BACK,
        S_SQ,
        S_ROOT,
        S_DONE
    } t_state;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic issue;  // operands are valid this cycle
        logic first;  // first term of a sum: restart the accumulator
        logic last;   // last term of a sum: flag the finished sum
    } t_mac_ctl;

endpackage

/* hw/rtl/mind_if.sv */
// ============================================================================
// mind_if: request channels of the minimum-image distance core
// Input pair channel, result channel and configuration write channel.
// ============================================================================
interface mind_in_if #(
    parameter int POS_WIDTH = mind_pkg::POS_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] center_x;
    logic signed [POS_WIDTH-1:0] center_y;
    logic signed [POS_WIDTH-1:0] center_z;
    logic signed [POS_WIDTH-1:0] neighbor_x;
    logic signed [POS_WIDTH-1:0] neighbor_y;
    logic signed [POS_WIDTH-1:0] neighbor_z;
    logic                        end_of_set;

    modport source (
        output valid, center_x, center_y, center_z,
        output neighbor_x, neighbor_y, neighbor_z, end_of_set,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z,
        input  neighbor_x, neighbor_y, neighbor_z, end_of_set,
        output ready
    );
endinterface

interface mind_out_if;
    logic                         valid;
    logic                         ready;
    logic [mind_pkg::OUT_W-1:0]   pair_distance;
    logic [mind_pkg::OUT_W-1:0]   running_max;
    logic                         final_result;

    modport source (
        output valid, pair_distance, running_max, final_result,
        input  ready
    );
    modport sink (
        input  valid, pair_distance, running_max, final_result,
        output ready
    );
endinterface

interface mind_cfg_if;
    logic                       valid;
    logic                       ready;
    mind_pkg::t_cfg_idx         index;
    logic [mind_pkg::REG_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hw/rtl/mind_mac.sv */
// ============================================================================
// mind_mac: shared signed multiply-accumulate unit
// One registered multiplier followed by a registered accumulator. A sum of
// terms issued on consecutive cycles is ready once its last term has passed both registers.
// ============================================================================
module mind_mac #(
    parameter int AW    = 21,
    parameter int BW    = 27,
    parameter int ACC_W = 50
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mind_pkg::t_mac_ctl      i_ctl,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_done
);

    logic signed [AW+BW-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     r_v1;
    logic                     r_first1;
    logic                     r_last1;
    logic                     r_done;

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Accumulate stage: restart on the first term of a sum.
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        n_acc = r_acc;
        if (r_v1) begin
            n_acc = r_first1 ? prod_ext : r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Term flags follow the data through both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_last1  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_v1     <= i_ctl.issue;
            r_first1 <= i_ctl.first;
            r_last1  <= i_ctl.last;
            r_done   <= r_v1 & r_last1;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

/* hw/rtl/mind_isqrt.sv */
// ============================================================================
// mind_isqrt: bit-serial integer square root
// Restoring digit-by-digit root, one result bit per cycle. The root is the
// floor of the square root and stays valid until the next start.
// ============================================================================
module mind_isqrt #(
    parameter int RT_W = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*RT_W-1:0]   i_rad,
    output logic                o_done,
    output logic [RT_W-1:0]     o_root
);

    localparam int SQ_W  = 2 * RT_W;
    localparam int RM_W  = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_rad;
    logic [RM_W-1:0]  r_rem;
    logic [RT_W-1:0]  r_root;

    logic [RM_W-1:0]  rem_shift;
    logic [RM_W-1:0]  trial;
    logic             fits;

    // One step: bring down two radicand bits and try the next root bit.
    assign rem_shift = {r_rem[RM_W-3:0], r_rad[SQ_W-1 -: 2]};
    assign trial     = RM_W'({r_root, 2'b01});
    assign fits      = rem_shift >= trial;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= fits ? rem_shift - trial : rem_shift;
            r_root <= {r_root[RT_W-2:0], fits};
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hw/rtl/min_image_neighbor_max_distance_core.sv */
// ============================================================================
// min_image_neighbor_max_distance_core: periodic minimum-image pair distance
// Maps each pair difference to fractional cell coordinates, wraps it to the
// nearest image, maps it back and takes the length, keeping a running maximum.
// ============================================================================
// Requests are taken only in the idle state, one at a time; the pace is set by the
// single shared multiplier (21 products) and the one-bit-per-cycle square root.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active low) clears the matrix registers and the maximum.
// ============================================================================
module min_image_neighbor_max_distance_core #(
    parameter int POS_WIDTH  = mind_pkg::POS_WIDTH_DEF,
    parameter int COEF_WIDTH = mind_pkg::COEF_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mind_cfg_if.sink    i_cfg,
    mind_in_if.sink     i_in,
    mind_out_if.source  o_out
);

    localparam int DW    = POS_WIDTH + 1;
    localparam int RW    = mind_pkg::REM_W;
    localparam int FS    = mind_pkg::FRAC_SHIFT;
    localparam int AW    = COEF_WIDTH + 1;
    localparam int BW    = (DW > RW) ? DW : RW;
    localparam int ACC_W = AW + BW + 2;
    localparam int RT_W  = COEF_WIDTH + 1;
    localparam int CW3   = 3 * COEF_WIDTH;
    localparam int OW    = mind_pkg::OUT_W;

    // Configuration registers.
    logic [mind_pkg::REG_W-1:0] r_cfg [mind_pkg::N_REGS];

    // Sequencer.
    mind_pkg::t_state r_state;
    mind_pkg::t_state n_state;
    logic [1:0]       r_row;
    logic [1:0]       r_col;
    logic [1:0]       r_res;
    logic             r_iss_end;
    logic [1:0]       last_row;
    logic             phase_end;

    // Per-request working registers.
    logic signed [DW-1:0]    r_delta [3];
    logic signed [RW-1:0]    r_rem [3];
    logic [COEF_WIDTH-1:0]   r_mag [3];
    logic                    r_last_in;
    logic [OW-1:0]           r_max;

    // Output register.
    logic          r_out_valid;
    logic [OW-1:0] r_out_dist;
    logic [OW-1:0] r_out_max;
    logic          r_out_final;

    // Shared unit connections.
    mind_pkg::t_mac_ctl       mac_ctl;
    logic signed [AW-1:0]     op_a;
    logic signed [BW-1:0]     op_b;
    logic signed [ACC_W-1:0]  acc;
    logic                     acc_done;
    logic                     sq_start;
    logic                     sq_done;
    logic [RT_W-1:0]          root;

    // Coefficient selection.
    mind_pkg::t_cfg_idx         sel_idx;
    logic [1:0]                 sel_k;
    logic [CW3-1:0]             sel_word;
    logic signed [COEF_WIDTH-1:0] coef;

    // Remainder and rounding logic on a finished sum.
    logic [FS-1:0]           acc_low;
    logic                    acc_neg;
    logic                    acc_tie;
    logic                    acc_up;
    logic signed [RW-1:0]    rem_val;
    logic signed [AW-1:0]    m_floor;
    logic signed [AW-1:0]    m_val;
    logic signed [AW-1:0]    m_abs;

    // Result logic.
    logic [OW-1:0] pair_dist;
    logic [OW-1:0] n_max;
    logic          out_load;
    logic          in_acc;

    // ------------------------------------------------------------------
    // Configuration writes; indexes past the register file are dropped.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mind_pkg::N_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg.valid && (i_cfg.index < mind_pkg::t_cfg_idx'(mind_pkg::N_REGS))) begin
            r_cfg[i_cfg.index] <= i_cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared multiply-accumulate unit.
    // Forward pass: row d of the inverse matrix times delta.
    // Backward pass: column k of the cell matrix times the remainders.
    // Square pass: each rounded magnitude times itself.
    // ------------------------------------------------------------------
    assign sel_word = CW3'(r_cfg[sel_idx]);
    assign coef     = sel_word[sel_k*COEF_WIDTH +: COEF_WIDTH];

    always_comb begin
        sel_idx = mind_pkg::REG_INV_X;
        sel_k   = r_col;
        op_a    = AW'(coef);
        op_b    = '0;
        case (r_state)
            mind_pkg::S_FRAC: begin
                sel_idx = mind_pkg::REG_INV_X + mind_pkg::t_cfg_idx'(r_row);
                sel_k   = r_col;
                op_a    = AW'(coef);
                op_b    = BW'(r_delta[r_col]);
            end
            mind_pkg::S_BACK: begin
                sel_idx = mind_pkg::REG_CELL_A + mind_pkg::t_cfg_idx'(r_col);
                sel_k   = r_row;
                op_a    = AW'(coef);
                op_b    = BW'(r_rem[r_col]);
            end
            mind_pkg::S_SQ: begin
                op_a = AW'(r_mag[r_col]);
                op_b = BW'(r_mag[r_col]);
            end
            default: begin
                op_b = '0;
            end
        endcase
    end

    assign last_row = (r_state == mind_pkg::S_SQ) ? 2'd0 : 2'd2;

    always_comb begin
        mac_ctl.issue = 1'b0;
        mac_ctl.first = (r_col == 2'd0);
        mac_ctl.last  = (r_col == 2'd2);
        if ((r_state == mind_pkg::S_FRAC || r_state == mind_pkg::S_BACK ||
             r_state == mind_pkg::S_SQ) && !r_iss_end) begin
            mac_ctl.issue = 1'b1;
        end
    end

    mind_mac #(
        .AW    (AW),
        .BW    (BW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_acc   (acc),
        .o_done  (acc_done)
    );

    // ------------------------------------------------------------------
    // Rounding of a finished sum, half away from zero, without taking the
    // absolute value: round up on a high low half, except on an exact tie
    // of a negative sum.
    // ------------------------------------------------------------------
    assign acc_low = acc[FS-1:0];
    assign acc_neg = acc[ACC_W-1];
    assign acc_tie = acc_low[FS-1] && (acc_low[FS-2:0] == '0);
    assign acc_up  = acc_low[FS-1] && !(acc_tie && acc_neg);

    // Remainder after removing the nearest integer cell offset.
    assign rem_val = {acc_up, acc_low};

    // Back-mapped component rounded to Q.8 and its magnitude.
    assign m_floor = acc[FS +: AW];
    assign m_val   = m_floor + AW'({1'b0, acc_up});
    assign m_abs   = m_val[AW-1] ? -m_val : m_val;

    // ------------------------------------------------------------------
    // Square root of the sum of squares.
    // ------------------------------------------------------------------
    assign sq_start = (r_state == mind_pkg::S_SQ) && acc_done;

    mind_isqrt #(
        .RT_W (RT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (acc[2*RT_W-1:0]),
        .o_done  (sq_done),
        .o_root  (root)
    );

    // ------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------
    assign phase_end = acc_done && (r_res == 2'd2);
    assign in_acc    = i_in.valid && i_in.ready;
    assign out_load  = (r_state == mind_pkg::S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mind_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = mind_pkg::S_FRAC;
                end
            end
            mind_pkg::S_FRAC: begin
                if (phase_end) begin
                    n_state = mind_pkg::S_BACK;
                end
            end
            mind_pkg::S_BACK: begin
                if (phase_end) begin
                    n_state = mind_pkg::S_SQ;
                end
            end
            mind_pkg::S_SQ: begin
                if (acc_done) begin
                    n_state = mind_pkg::S_ROOT;
                end
            end
            mind_pkg::S_ROOT: begin
                if (sq_done) begin
                    n_state = mind_pkg::S_DONE;
                end
            end
            mind_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = mind_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mind_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready = (r_state == mind_pkg::S_IDLE);

    // State register and term counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mind_pkg::S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_res     <= '0;
            r_iss_end <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_row     <= '0;
                r_col     <= '0;
                r_res     <= '0;
                r_iss_end <= 1'b0;
            end else begin
                if (mac_ctl.issue) begin
                    if (r_col == 2'd2) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                        if (r_row == last_row) begin
                            r_iss_end <= 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                if (acc_done) begin
                    r_res <= r_res + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Working registers: differences on accept, remainders and magnitudes
    // as each sum finishes.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_delta[0] <= DW'(i_in.neighbor_x) - DW'(i_in.center_x);
            r_delta[1] <= DW'(i_in.neighbor_y) - DW'(i_in.center_y);
            r_delta[2] <= DW'(i_in.neighbor_z) - DW'(i_in.center_z);
            r_last_in  <= i_in.end_of_set;
        end
        if (acc_done && (r_state == mind_pkg::S_FRAC)) begin
            r_rem[r_res] <= rem_val;
        end
        if (acc_done && (r_state == mind_pkg::S_BACK)) begin
            r_mag[r_res] <= m_abs[COEF_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result, running maximum and output register. The root is at most
    // COEF_WIDTH + 1 bits, so it fits the OUT_W-bit output range for COEF_WIDTH up to 23.
    // ------------------------------------------------------------------
    assign pair_dist = OW'(root);
    assign n_max     = (pair_dist > r_max) ? pair_dist : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_max       <= r_last_in ? '0 : n_max;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dist  <= pair_dist;
            r_out_max   <= n_max;
            r_out_final <= r_last_in;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pair_distance = r_out_dist;
    assign o_out.running_max   = r_out_max;
    assign o_out.final_result  = r_out_final;

endmodule
